// ===== rtl/core/nearest_vertex_search_3d_top_assert.svh =====
// ----------------------------------------------------------------------------
// Nearest vertex search assertion macros
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_SEARCH_3D_TOP_ASSERT_SVH
`define NEAREST_VERTEX_SEARCH_3D_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/nvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared widths, codes and control types for the nearest vertex search.
// ----------------------------------------------------------------------------
`default_nettype none

package nvs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int COORD_W      = 16;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int DIST_W       = SQ_W + 2;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 96;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } nvs_state_t;

  typedef struct packed {
    logic             wr;
    logic             start;
    logic             rd;
    logic [IDX_W-1:0] addr;
    logic             out_load;
  } nvs_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } nvs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/nearest_vertex_search_3d_top.sv =====
// Load beat: taken while idle, written to the vertex store, no result.
// Query beat: scans vertex_count entries at one store read per cycle, then the
// distance pipe drains and the result is loaded for output; no beat is taken
// until that load, and a result still waiting holds off the next one.
// rst_n is synchronous, active low: control clears, vertex_count returns to 1;
// the vertex store is not cleared and holds nothing valid until loaded.
// ----------------------------------------------------------------------------
// nearest_vertex_search_3d_top
// Linear nearest-vertex search over a loadable 3-D vertex table.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_vertex_search_3d_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // vertex_index[9:0], coord_x[25:10], coord_y[41:26], coord_t[57:42], zero
  input  wire  [nvs_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // best_index[9:0], best_x[25:10], best_y[41:26], best_t[57:42],
  // nearest_sqdist[91:58], zero
  output logic [nvs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                               cfg_we,
  // vertex_count
  input  wire  [nvs_pkg::CNT_W-1:0]         cfg_wdata
);
  import nvs_pkg::*;

  nvs_cmd_t cmd;
  nvs_sts_t sts;

  nvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  nvs_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_index (in_tdata[IDX_W-1:0]),
    .in_x     (in_tdata[IDX_W+COORD_W-1:IDX_W]),
    .in_y     (in_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W]),
    .in_t     (in_tdata[IDX_W+3*COORD_W-1:IDX_W+2*COORD_W]),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/nvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvs_ctrl
// Sequencer: load/query decode, scan address counter, result handover.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_vertex_search_3d_top_assert.svh"

module nvs_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire                          in_tuser,
  input  wire                          cfg_we,
  input  wire  [nvs_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output nvs_pkg::nvs_cmd_t            cmd,
  input  wire  nvs_pkg::nvs_sts_t      sts
);
  import nvs_pkg::*;

  nvs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0] vertex_count_r;
  logic             out_valid_r, out_valid_nxt;

  // zero counts as one, anything past the table as the full table
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0)
      r = CNT_W'(1);
    else if (v > CNT_W'(MAX_VERTICES))
      r = CNT_W'(MAX_VERTICES);
    return r;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.addr      = scan_cnt_r[IDX_W-1:0];
    if (out_valid_r && out_tready)
      out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_LOAD) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start    = 1'b1;
            scan_cnt_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd       = 1'b1;
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        if (scan_cnt_r + CNT_W'(1) == vertex_count_r)
          state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the pipe to empty and the output register to free up
        if (!sts.pipe_busy && (!out_valid_r || out_tready)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      scan_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= CNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we)
        vertex_count_r <= clamp_count(cfg_wdata);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  `NVS_ASSERT_IMP(a_scan_in_range, state_r == ST_SCAN, scan_cnt_r < vertex_count_r, "scan address past vertex count")
  `NVS_ASSERT_IMP(a_count_range, 1'b1, vertex_count_r != '0 && vertex_count_r <= CNT_W'(MAX_VERTICES), "vertex count out of range")
  `NVS_ASSERT_NXT(a_start_scan, cmd.start, state_r == ST_SCAN && scan_cnt_r == '0, "query did not start scan at entry zero")
  `NVS_ASSERT_NXT(a_drain_done, state_r == ST_DRAIN && !sts.pipe_busy && !out_valid_r, out_valid_r && state_r == ST_IDLE, "drained result not handed over")

endmodule

`default_nettype wire

// ===== rtl/core/nvs_dpath.sv =====
// ----------------------------------------------------------------------------
// nvs_dpath
// Vertex store, distance pipeline, running minimum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_dpath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  nvs_pkg::nvs_cmd_t         cmd,
  output nvs_pkg::nvs_sts_t               sts,
  input  wire  [nvs_pkg::IDX_W-1:0]       in_index,
  input  wire  [nvs_pkg::COORD_W-1:0]     in_x,
  input  wire  [nvs_pkg::COORD_W-1:0]     in_y,
  input  wire  [nvs_pkg::COORD_W-1:0]     in_t,
  output logic [nvs_pkg::OUT_DATA_W-1:0]  out_data
);
  import nvs_pkg::*;

  localparam int ENT_W = 3 * COORD_W;
  localparam int PAD_W = OUT_DATA_W - IDX_W - ENT_W - DIST_W;

  logic [ENT_W-1:0] mem [MAX_VERTICES];

  // query point
  logic [COORD_W-1:0] qx_r, qy_r, qt_r;

  // stage 1: read data
  logic               s1_vld_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [ENT_W-1:0]   s1_ent_r;
  // stage 2: absolute differences
  logic               s2_vld_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [ENT_W-1:0]   s2_ent_r;
  logic [COORD_W-1:0] s2_dx_r, s2_dy_r, s2_dt_r;
  // stage 3: squares
  logic               s3_vld_r;
  logic [IDX_W-1:0]   s3_idx_r;
  logic [ENT_W-1:0]   s3_ent_r;
  logic [SQ_W-1:0]    s3_sx_r, s3_sy_r, s3_st_r;
  // stage 4: distance
  logic               s4_vld_r;
  logic [IDX_W-1:0]   s4_idx_r;
  logic [ENT_W-1:0]   s4_ent_r;
  logic [DIST_W-1:0]  s4_dist_r;
  // running best
  logic               have_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [ENT_W-1:0]   best_ent_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [COORD_W-1:0] dx, dy, dt;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W])
      d = ~d + (COORD_W+1)'(1);
    return d[COORD_W-1:0];
  endfunction

  always_comb begin
    dx = abs_diff(qx_r, s1_ent_r[COORD_W-1:0]);
    dy = abs_diff(qy_r, s1_ent_r[2*COORD_W-1:COORD_W]);
    dt = abs_diff(qt_r, s1_ent_r[3*COORD_W-1:2*COORD_W]);
  end

  // store: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (cmd.wr)
      mem[in_index] <= {in_t, in_y, in_x};
    if (cmd.rd)
      s1_ent_r <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_x;
      qy_r <= in_y;
      qt_r <= in_t;
    end
    s1_idx_r <= cmd.addr;
    s2_idx_r <= s1_idx_r;
    s2_ent_r <= s1_ent_r;
    s2_dx_r  <= dx;
    s2_dy_r  <= dy;
    s2_dt_r  <= dt;
    s3_idx_r <= s2_idx_r;
    s3_ent_r <= s2_ent_r;
    s3_sx_r  <= SQ_W'(s2_dx_r) * SQ_W'(s2_dx_r);
    s3_sy_r  <= SQ_W'(s2_dy_r) * SQ_W'(s2_dy_r);
    s3_st_r  <= SQ_W'(s2_dt_r) * SQ_W'(s2_dt_r);
    s4_idx_r <= s3_idx_r;
    s4_ent_r <= s3_ent_r;
    s4_dist_r <= DIST_W'(s3_sx_r) + DIST_W'(s3_sy_r) + DIST_W'(s3_st_r);
    // strict less-than keeps the lowest index on a tie
    if (s4_vld_r && (!have_r || s4_dist_r < best_dist_r)) begin
      best_idx_r  <= s4_idx_r;
      best_ent_r  <= s4_ent_r;
      best_dist_r <= s4_dist_r;
    end
    if (cmd.out_load)
      out_data_r <= {PAD_W'(0), best_dist_r, best_ent_r, best_idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      if (cmd.start)
        have_r <= 1'b0;
      else if (s4_vld_r)
        have_r <= 1'b1;
    end
  end

  assign sts.pipe_busy = s1_vld_r | s2_vld_r | s3_vld_r | s4_vld_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

// ===== dv/nearest_vertex_search_3d_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_vertex_search_3d_top_tb
// Loads vertex tables and issues nearest-vertex queries over the stream ports.
// A local copy of the table predicts each query result not given in the plan;
// every returned beat is checked field by field. A directed table runs first,
// then random phases over a range of vertex counts and back-pressure patterns.
// ----------------------------------------------------------------------------
module nearest_vertex_search_3d_top_tb;
  import nvs_pkg::*;

  localparam int LOAD_SETTLE = 16;   // wait after the last beat before a count write or the end
  localparam int HOLD_AFTER  = 30;   // results taken before the long receiver stall
  localparam int HOLD_LEN    = 400;
  localparam int N_PHASES    = 9;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] t;
    logic [DIST_W-1:0]         sqd;
  } hit_t;

  typedef enum logic [1:0] {SK_LOAD, SK_QUERY, SK_CFG} step_kind_t;

  typedef struct {
    step_kind_t                kind;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] t;
    logic [CNT_W-1:0]          count;
    bit                        typed;
    hit_t                      want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  // local copy of the vertex table and count register
  logic signed [COORD_W-1:0] tbl_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] tbl_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] tbl_t [MAX_VERTICES];
  bit                        tbl_loaded [MAX_VERTICES];
  logic [CNT_W-1:0]          vcount = CNT_W'(1);

  hit_t hits_due[$];
  int   n_err = 0;
  int   n_hits = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   hold_left = 0;
  bit   held = 1'b0;

  nearest_vertex_search_3d_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // zero counts as one, anything past the table as the whole table
  function automatic int scan_len();
    if (vcount == 0) return 1;
    if (vcount > MAX_VERTICES) return MAX_VERTICES;
    return int'(vcount);
  endfunction

  function automatic hit_t nearest(logic signed [COORD_W-1:0] qx,
                                   logic signed [COORD_W-1:0] qy,
                                   logic signed [COORD_W-1:0] qt);
    hit_t   h;
    longint dx, dy, dt, d, best;
    int     n;
    h = '0;
    best = 0;
    n = scan_len();
    for (int i = 0; i < n; i++) begin
      dx = longint'(qx) - longint'(tbl_x[i]);
      dy = longint'(qy) - longint'(tbl_y[i]);
      dt = longint'(qt) - longint'(tbl_t[i]);
      d = dx * dx + dy * dy + dt * dt;
      // strict compare keeps the first minimum
      if (i == 0 || d < best) begin
        best = d;
        h.idx = IDX_W'(i);
        h.x = tbl_x[i];
        h.y = tbl_y[i];
        h.t = tbl_t[i];
      end
    end
    h.sqd = DIST_W'(best);
    return h;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return COORD_W'($urandom_range(8)) - COORD_W'(4);  // clustered, ties likely
      3:       return ($urandom_range(1) != 0) ? {1'b0, {(COORD_W-1){1'b1}}}
                                               : {1'b1, {(COORD_W-1){1'b0}}};
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic plan_row_t row(step_kind_t k, int idx, int x, int y, int t,
                                    int cnt = 0, bit typed = 1'b0, int w_idx = 0,
                                    int w_x = 0, int w_y = 0, int w_t = 0,
                                    longint w_dist = 0);
    plan_row_t r;
    r.kind = k;
    r.idx = IDX_W'(idx);
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.t = COORD_W'(t);
    r.count = CNT_W'(cnt);
    r.typed = typed;
    r.want.idx = IDX_W'(w_idx);
    r.want.x = COORD_W'(w_x);
    r.want.y = COORD_W'(w_y);
    r.want.t = COORD_W'(w_t);
    r.want.sqd = DIST_W'(w_dist);
    return r;
  endfunction

  task automatic send_beat(logic op, logic [IDX_W-1:0] idx,
                           logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y,
                           logic signed [COORD_W-1:0] t,
                           bit typed, hit_t want);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IDX_W - 3*COORD_W){1'b0}}, t, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      tbl_x[idx] = x;
      tbl_y[idx] = y;
      tbl_t[idx] = t;
      tbl_loaded[idx] = 1'b1;
    end else begin
      hits_due.insert(hits_due.size(), typed ? want : nearest(x, y, t));
    end
  endtask

  // only once all queries are back and the last load has settled
  task automatic write_count(logic [CNT_W-1:0] v);
    in_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = v;
  endtask

  task automatic cmp(string name, longint want, longint got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_hit(logic [OUT_DATA_W-1:0] d);
    hit_t got, want;
    got.idx  = d[IDX_W-1:0];
    got.x    = d[IDX_W +: COORD_W];
    got.y    = d[IDX_W + COORD_W +: COORD_W];
    got.t    = d[IDX_W + 2*COORD_W +: COORD_W];
    got.sqd  = d[IDX_W + 3*COORD_W +: DIST_W];
    if (hits_due.size() == 0) begin
      n_err++;
      $display("%0t: unexpected result, expected none, actual index %0d distance %0d",
               $time, got.idx, got.sqd);
    end else begin
      want = hits_due.pop_front();
      cmp("best_index", want.idx, got.idx);
      cmp("best_x", $signed(want.x), $signed(got.x));
      cmp("best_y", $signed(want.y), $signed(got.y));
      cmp("best_t", $signed(want.t), $signed(got.t));
      cmp("nearest_sqdist", want.sqd, got.sqd);
    end
  endtask

  // result side: check each beat, then decide next cycle's ready
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      check_hit(out_tdata);
      n_hits++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held && n_hits == HOLD_AFTER) begin
      // long stall so queued queries back up into the input
      held = 1'b1;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    plan_row_t        plan[$];
    int               ph_count [N_PHASES];
    int               ph_items [N_PHASES];
    logic [IDX_W-1:0] at;

    ph_count = '{3, 1, 16, 6, 40, 2, 11, 48, 25};
    ph_items = '{70, 50, 80, 80, 80, 60, 70, 20, 10};

    plan.insert(plan.size(), row(SK_LOAD, 0, -32768, -32768, -32768));
    // reset count of one: only entry 0 is scanned
    plan.insert(plan.size(), row(SK_QUERY, 0, 32767, 32767, 32767, 0, 1'b1,
                                 0, -32768, -32768, -32768, 64'd12884508675));
    plan.insert(plan.size(), row(SK_QUERY, 0, -32768, -32768, -32768, 0, 1'b1,
                                 0, -32768, -32768, -32768, 64'd0));
    plan.insert(plan.size(), row(SK_LOAD, 0, 32767, 32767, 32767));
    plan.insert(plan.size(), row(SK_QUERY, 1023, -32768, -32768, -32768, 0, 1'b1,
                                 0, 32767, 32767, 32767, 64'd12884508675));
    plan.insert(plan.size(), row(SK_QUERY, 1023, 0, 0, 0, 0, 1'b1,
                                 0, 32767, 32767, 32767, 64'd3221028867));
    plan.insert(plan.size(), row(SK_LOAD, 1023, 12345, -1, 0));
    // zero count behaves as one
    plan.insert(plan.size(), row(SK_CFG, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), row(SK_QUERY, 0, 32767, 32767, 32767, 0, 1'b1,
                                 0, 32767, 32767, 32767, 64'd0));
    plan.insert(plan.size(), row(SK_LOAD, 1, 1, 0, 0));
    plan.insert(plan.size(), row(SK_LOAD, 2, -1, 0, 0));
    plan.insert(plan.size(), row(SK_LOAD, 3, 0, 1, 0));
    plan.insert(plan.size(), row(SK_CFG, 0, 0, 0, 0, 4));
    // three entries tie at distance 1, lowest index must win
    plan.insert(plan.size(), row(SK_QUERY, 0, 0, 0, 0));
    plan.insert(plan.size(), row(SK_QUERY, 0, -1, 0, 0));
    plan.insert(plan.size(), row(SK_QUERY, 0, 0, 1, -1));
    plan.insert(plan.size(), row(SK_QUERY, 0, 100, -200, 300));
    plan.insert(plan.size(), row(SK_LOAD, 0, -5, -5, -5));
    plan.insert(plan.size(), row(SK_QUERY, 0, -32768, 32767, -32768));
    plan.insert(plan.size(), row(SK_QUERY, 0, -4, -4, -4));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 11;
    rcv_idle = 73;
    foreach (plan[i]) begin
      case (plan[i].kind)
        SK_CFG:  write_count(plan[i].count);
        SK_LOAD: send_beat(OP_LOAD, plan[i].idx, plan[i].x, plan[i].y, plan[i].t,
                           1'b0, '0);
        default: send_beat(OP_QUERY, plan[i].idx, plan[i].x, plan[i].y, plan[i].t,
                           plan[i].typed, plan[i].want);
      endcase
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        snd_idle = 11;
        rcv_idle = 73;
      end else if (p < 6) begin
        snd_idle = 73;
        rcv_idle = 11;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_count(CNT_W'(ph_count[p]));
      // every scanned entry must hold a loaded vertex before any query
      for (int i = 0; i < scan_len(); i++)
        if (!tbl_loaded[i])
          send_beat(OP_LOAD, IDX_W'(i), rand_coord(), rand_coord(), rand_coord(),
                    1'b0, '0);
      repeat (ph_items[p]) begin
        if ($urandom_range(1) != 0) begin
          send_beat(OP_QUERY, IDX_W'($urandom()), rand_coord(), rand_coord(),
                    rand_coord(), 1'b0, '0);
        end else begin
          at = ($urandom_range(9) < 7) ? IDX_W'($urandom_range(scan_len() - 1))
                                       : IDX_W'($urandom());
          send_beat(OP_LOAD, at, rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (scan_len() + LOAD_SETTLE) @(posedge clk);
    if (n_err == 0 && hits_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nvs_pkg.sv
rtl/core/nvs_ctrl.sv
rtl/core/nvs_dpath.sv
rtl/core/nearest_vertex_search_3d_top.sv
dv/nearest_vertex_search_3d_top_tb.sv
